// File: rtl/sbst_pkg.sv
// ----------------------------------------------------------------------------
// sbst_pkg
// Shared constants and pair tables for the segment versus box slab test.
// ----------------------------------------------------------------------------
`default_nettype none

package sbst_pkg;

  // default coordinate width (signed Q16.16)
  localparam int unsigned COORD_WIDTH_DEF = 32;

  // padding register
  localparam int unsigned PAD_WIDTH = 31;
  localparam logic [PAD_WIDTH-1:0] PAD_RESET = PAD_WIDTH'(16384);

  // ordered pairs of distinct axes compared by cross multiplication
  localparam int unsigned NUM_PAIRS = 6;

  // axis whose entry t is on the left side of the compare
  function automatic logic [1:0] pair_in_axis(input logic [2:0] k);
    logic [1:0] r;
    case (k)
      3'd0, 3'd1: r = 2'd0;
      3'd2, 3'd3: r = 2'd1;
      default:    r = 2'd2;
    endcase
    return r;
  endfunction

  // axis whose exit t is on the right side of the compare
  function automatic logic [1:0] pair_out_axis(input logic [2:0] k);
    logic [1:0] r;
    case (k)
      3'd0:       r = 2'd1;
      3'd1:       r = 2'd2;
      3'd2:       r = 2'd0;
      3'd3:       r = 2'd2;
      3'd4:       r = 2'd0;
      default:    r = 2'd1;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/segment_box_slab_test.sv
// ----------------------------------------------------------------------------
// segment_box_slab_test
// Segment versus padded axis-aligned box hit test, slab method, pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o with start, end, box center and
//   half extents, signed Q16.16. Output channel: out_valid_o / out_stall_i
//   with the one-bit hit flag, one result per request.
//   cfg_we_i writes cfg_wdata_i into the padding register (reset 0.25),
//   which is added to every half extent. Write it only while idle.
// Pipeline: three register stages, the first loaded at the accepting edge;
//   out_valid_o comes from the third.
// Throughput: one request per cycle while the output is not stalled. The stages are
//   slab bounds and t numerators/denominators, split partial products of the t
//   cross multiplications, and product sum plus compare into the output register.
// Reset clears all stage valid bits; the padding returns to 0.25.
// A stall on a valid output freezes the whole pipeline; in_stall_o rises in the
//   same cycle, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_box_slab_test
  import sbst_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [PAD_WIDTH-1:0]          cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [COORD_WIDTH-1:0] start_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] start_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] start_z_i,
  input  wire logic signed [COORD_WIDTH-1:0] end_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] end_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] end_z_i,
  input  wire logic signed [COORD_WIDTH-1:0] box_center_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] box_center_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] box_center_z_i,
  input  wire logic [COORD_WIDTH-2:0]        half_size_x_i,
  input  wire logic [COORD_WIDTH-2:0]        half_size_y_i,
  input  wire logic [COORD_WIDTH-2:0]        half_size_z_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               hit_o
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned EW = ((W > PAD_WIDTH) ? W : PAD_WIDTH) + 4; // bounds
  localparam int unsigned DW = W + 1;                                 // |motion|
  localparam int unsigned DL = DW / 2;
  localparam int unsigned DH = DW - DL;
  localparam int unsigned PW = EW + DW + 1;                           // products

  // padding register
  logic [PAD_WIDTH-1:0] pad_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_q <= PAD_RESET;
    end else if (cfg_we_i) begin
      pad_q <= cfg_wdata_i;
    end
  end

  // pipeline advance: the whole pipe holds while a valid output is stalled
  logic adv;
  logic out_valid_q;
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  // gather axes
  logic signed [W-1:0] p_a [3];
  logic signed [W-1:0] q_a [3];
  logic signed [W-1:0] c_a [3];
  logic [W-2:0]        h_a [3];
  always_comb begin
    p_a[0] = start_x_i;      p_a[1] = start_y_i;      p_a[2] = start_z_i;
    q_a[0] = end_x_i;        q_a[1] = end_y_i;        q_a[2] = end_z_i;
    c_a[0] = box_center_x_i; c_a[1] = box_center_y_i; c_a[2] = box_center_z_i;
    h_a[0] = half_size_x_i;  h_a[1] = half_size_y_i;  h_a[2] = half_size_z_i;
  end

  // ---------------- stage 1: slab bounds, numerators, denominators --------
  logic signed [EW-1:0] nin_d  [3];
  logic signed [EW-1:0] nout_d [3];
  logic [DW-1:0]        den_d  [3];
  logic [2:0]           mov_d;
  logic [2:0]           aok_d;

  logic signed [EW-1:0] nin_q  [3];
  logic signed [EW-1:0] nout_q [3];
  logic [DW-1:0]        den_q  [3];
  logic [2:0]           mov_q;
  logic                 ok1_q;
  logic                 v1_q;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [EW-1:0] ps, qs, cs, ext, mn, mx, dd, dmag, den_e;
    always_comb begin
      ps    = EW'(p_a[a]);
      qs    = EW'(q_a[a]);
      cs    = EW'(c_a[a]);
      ext   = $signed(EW'(h_a[a])) + $signed(EW'(pad_q));
      mn    = cs - ext;
      mx    = cs + ext;
      dd    = qs - ps;
      dmag  = dd[EW-1] ? -dd : dd;
      mov_d[a] = (dd != '0);
      den_d[a] = dmag[DW-1:0];
      den_e    = $signed(EW'(den_d[a]));
      if (!mov_d[a]) begin
        nin_d[a]  = '0;
        nout_d[a] = '0;
        aok_d[a]  = (ps >= mn) && (ps <= mx);
      end else begin
        if (!dd[EW-1]) begin
          nin_d[a]  = mn - ps;
          nout_d[a] = mx - ps;
        end else begin
          nin_d[a]  = ps - mx;
          nout_d[a] = ps - mn;
        end
        // entry after t=1 or exit before t=0
        aok_d[a] = !((nin_d[a] > den_e) || (nout_d[a] < 0));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nin_q  <= nin_d;
      nout_q <= nout_d;
      den_q  <= den_d;
      mov_q  <= mov_d;
      ok1_q  <= &aok_d;
    end
  end

  // ---------------- stage 2: partial products of the cross compares -------
  // entry[i] <= exit[j]  <=>  nin[i]*den[j] <= nout[j]*den[i]
  logic signed [EW+DL:0] al_q [NUM_PAIRS];
  logic signed [EW+DH:0] ah_q [NUM_PAIRS];
  logic signed [EW+DL:0] bl_q [NUM_PAIRS];
  logic signed [EW+DH:0] bh_q [NUM_PAIRS];
  logic [NUM_PAIRS-1:0]  need_q;
  logic                  ok2_q;
  logic                  v2_q;

  for (genvar k = 0; k < NUM_PAIRS; k++) begin : g_pair
    localparam logic [1:0] AI = pair_in_axis(3'(k));
    localparam logic [1:0] AJ = pair_out_axis(3'(k));
    always_ff @(posedge clk_i) begin
      if (adv) begin
        al_q[k]   <= nin_q[AI]  * $signed({1'b0, den_q[AJ][DL-1:0]});
        ah_q[k]   <= nin_q[AI]  * $signed({1'b0, den_q[AJ][DW-1:DL]});
        bl_q[k]   <= nout_q[AJ] * $signed({1'b0, den_q[AI][DL-1:0]});
        bh_q[k]   <= nout_q[AJ] * $signed({1'b0, den_q[AI][DW-1:DL]});
        need_q[k] <= mov_q[AI] && mov_q[AJ];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ok2_q <= ok1_q;
    end
  end

  // ---------------- stage 3: sum partials, compare, output register -------
  logic [NUM_PAIRS-1:0] pass;
  for (genvar k = 0; k < NUM_PAIRS; k++) begin : g_cmp
    logic signed [PW-1:0] lhs, rhs;
    always_comb begin
      lhs = (PW'(ah_q[k]) <<< DL) + PW'(al_q[k]);
      rhs = (PW'(bh_q[k]) <<< DL) + PW'(bl_q[k]);
      pass[k] = !need_q[k] || (lhs <= rhs);
    end
  end

  logic hit_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_q <= ok2_q && (&pass);
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;

endmodule

`default_nettype wire

// File: tb/sv/tb_segment_box_slab_test.sv
// ----------------------------------------------------------------------------
// tb_segment_box_slab_test
// Directed and random test of the segment versus padded box slab test.
// Every request is scored against an exact integer slab test kept in the
// bench. Both sides insert random gaps, and the padding register is swept.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_segment_box_slab_test
  import sbst_pkg::*;
();

  localparam int unsigned CW = 32;
  localparam int unsigned WATCH_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [PAD_WIDTH-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [CW-1:0] st_i [3];
  logic signed [CW-1:0] en_i [3];
  logic signed [CW-1:0] ce_i [3];
  logic [CW-2:0] hs_i [3];
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic hit_o;

  // golden copy of the padding register
  logic [PAD_WIDTH-1:0] pad_model;
  bit hit_queue [$];
  int err_count = 0;
  int idle_cycles = 0;
  int rx_wait = 0;
  bit rx_random = 1'b1;

  initial begin
    for (int a = 0; a < 3; a++) begin
      st_i[a] = '0; en_i[a] = '0; ce_i[a] = '0; hs_i[a] = '0;
    end
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  segment_box_slab_test #(.COORD_WIDTH(CW)) i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .start_x_i(st_i[0]), .start_y_i(st_i[1]), .start_z_i(st_i[2]),
    .end_x_i(en_i[0]), .end_y_i(en_i[1]), .end_z_i(en_i[2]),
    .box_center_x_i(ce_i[0]), .box_center_y_i(ce_i[1]), .box_center_z_i(ce_i[2]),
    .half_size_x_i(hs_i[0]), .half_size_y_i(hs_i[1]), .half_size_z_i(hs_i[2]),
    .out_valid_o, .out_stall_i, .hit_o
  );

  // exact slab test; t values compared by cross multiplication
  function automatic bit slab_hit(
      input logic signed [CW-1:0] p [3], input logic signed [CW-1:0] q [3],
      input logic signed [CW-1:0] c [3], input logic [CW-2:0] h [3],
      input logic [PAD_WIDTH-1:0] pad);
    longint t_in [3];
    longint t_out [3];
    longint t_den [3];
    bit mov [3];
    bit hit;
    longint ext, mn, mx, d;
    logic signed [127:0] lhs, rhs;
    hit = 1'b1;
    for (int a = 0; a < 3; a++) begin
      ext = longint'(h[a]) + longint'(pad);
      mn = longint'(c[a]) - ext;
      mx = longint'(c[a]) + ext;
      d = longint'(q[a]) - longint'(p[a]);
      mov[a] = (d != 0);
      t_in[a] = 0; t_out[a] = 0; t_den[a] = 1;
      if (d == 0) begin
        if (longint'(p[a]) < mn || longint'(p[a]) > mx) hit = 1'b0;
      end else if (d > 0) begin
        t_in[a] = mn - p[a]; t_out[a] = mx - p[a]; t_den[a] = d;
      end else begin
        t_in[a] = p[a] - mx; t_out[a] = p[a] - mn; t_den[a] = -d;
      end
    end
    for (int a = 0; a < 3; a++) begin
      if (hit && mov[a]) begin
        if (t_in[a] > t_den[a] || t_out[a] < 0) hit = 1'b0;
        for (int b = 0; b < 3; b++) begin
          if (hit && mov[b]) begin
            lhs = 128'(signed'(t_in[a])) * 128'(signed'(t_den[b]));
            rhs = 128'(signed'(t_out[b])) * 128'(signed'(t_den[a]));
            if (lhs > rhs) hit = 1'b0;
          end
        end
      end
    end
    return hit;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    err_count++;
  endtask

  // send one request after an optional random gap; valid stays up for back to back
  task automatic send_request(input logic signed [CW-1:0] p [3],
      input logic signed [CW-1:0] q [3], input logic signed [CW-1:0] c [3],
      input logic [CW-2:0] h [3], input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    for (int a = 0; a < 3; a++) begin
      st_i[a] <= p[a]; en_i[a] <= q[a]; ce_i[a] <= c[a]; hs_i[a] <= h[a];
    end
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    hit_queue.insert(hit_queue.size(), slab_hit(p, q, c, h, pad_model));
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (hit_queue.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_padding(input logic [PAD_WIDTH-1:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pad_model = v;
  endtask

  // output side: random wait per result, compare each accepted result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (hit_queue.size() == 0) report_mismatch("result with no request pending");
        else begin
          bit e;
          e = hit_queue.pop_front();
          if (hit_o !== e) report_mismatch($sformatf("hit %0b expected %0b", hit_o, e));
        end
        rx_wait = rx_random ? $urandom_range(0, 5) : 0;
      end else if (rx_wait > 0) begin
        rx_wait = rx_wait - 1;
      end
      out_stall_i <= (rx_wait != 0);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic signed [CW-1:0] rnd_coord(input int mode);
    case (mode)
      0: return $signed($urandom());
      1: return $signed(CW'(int'($urandom_range(0, 8 << 16)) - (4 << 16)));
      default: return $signed(CW'(int'($urandom_range(0, 64)) - 32) <<< 16);
    endcase
  endfunction

  task automatic random_request(input int mode);
    logic signed [CW-1:0] p [3];
    logic signed [CW-1:0] q [3];
    logic signed [CW-1:0] c [3];
    logic [CW-2:0] h [3];
    for (int a = 0; a < 3; a++) begin
      p[a] = rnd_coord(mode);
      q[a] = ($urandom_range(0, 5) == 0) ? p[a] : rnd_coord(mode);
      c[a] = rnd_coord(mode);
      h[a] = (mode == 0) ? (CW-1)'($urandom()) : (CW-1)'($urandom_range(0, 3 << 16));
    end
    send_request(p, q, c, h, 1'b1);
  endtask

  // extremes, zero motion, point tests, touching edges
  task automatic test_directed;
    logic signed [CW-1:0] p [3];
    logic signed [CW-1:0] q [3];
    logic signed [CW-1:0] c [3];
    logic [CW-2:0] h [3];
    for (int k = 0; k < 20; k++) begin
      for (int a = 0; a < 3; a++) begin
        case (k % 5)
          0: begin p[a] = '0; q[a] = '0; c[a] = '0; h[a] = '0; end
          1: begin
            p[a] = {1'b1, {(CW-1){1'b0}}}; q[a] = {1'b0, {(CW-1){1'b1}}};
            c[a] = '0; h[a] = '1;
          end
          2: begin
            p[a] = {1'b0, {(CW-1){1'b1}}}; q[a] = {1'b1, {(CW-1){1'b0}}};
            c[a] = (k > 10) ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
            h[a] = '0;
          end
          3: begin
            p[a] = 32'sd5 <<< 16; q[a] = (a == k % 3) ? p[a] : -(32'sd5 <<< 16);
            c[a] = 32'sd2 <<< 16; h[a] = (k > 10) ? 31'd1 << 16 : '1;
          end
          default: begin
            p[a] = 32'sd1 <<< 16; q[a] = 32'sd3 <<< 16;
            c[a] = 32'sd0; h[a] = 31'd1 << 16;
          end
        endcase
      end
      send_request(p, q, c, h, k[0]);
    end
  endtask

  task automatic test_random(input int count);
    for (int n = 0; n < count; n++) begin
      random_request($urandom_range(0, 2));
      if (n == count / 2) begin
        rx_random = 1'b0;
        repeat (100) random_request(1);
        rx_random = 1'b1;
        drain();
      end
    end
  endtask

  task automatic test_padding_sweep;
    write_padding('0);
    test_random(250);
    write_padding('1);
    test_random(250);
    write_padding(PAD_WIDTH'(1 << 16));
    test_random(250);
    write_padding(PAD_WIDTH'($urandom()));
    test_random(250);
  endtask

  initial begin
    pad_model = PAD_RESET;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(500);
    test_padding_sweep();
    drain();
    if (err_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
